[hw/rtl/opa_pkg.sv]
// Shared types, field widths and constants of the OFDM PPDU air time calculator.
// No dependencies; used by opa_div_stage and ofdm_ppdu_airtime.
package opa_pkg;

  localparam int unsigned PsduW      = 20;
  localparam int unsigned BpsW       = 12;
  localparam int unsigned StreamW    = 3;
  localparam int unsigned ModeW      = 2;
  localparam int unsigned GuardW     = 16;
  localparam int unsigned SymBaseW   = 16;
  localparam int unsigned BitsCfgW   = 8;
  localparam int unsigned CfgIdxW    = 2;
  localparam int unsigned CfgDataW   = 16;
  localparam int unsigned SymW       = 17;
  localparam int unsigned PreW       = 20;
  localparam int unsigned SymTotW    = 20;
  localparam int unsigned AirW       = 38;
  localparam int unsigned ProdW      = SymTotW + SymW;
  localparam int unsigned DivW       = 21;
  localparam int unsigned RemW       = BpsW;
  localparam int unsigned StepsPerStage = 3;
  localparam int unsigned DivStages  = (DivW + StepsPerStage - 1) / StepsPerStage;

  localparam logic [SymBaseW-1:0] SymBaseRst = 16'd3200;
  localparam logic [BitsCfgW-1:0] ServiceRst = 8'd16;
  localparam logic [BitsCfgW-1:0] TailRst    = 8'd6;

  localparam logic [PreW-1:0] BasicFixNs = 20'd16000;
  localparam logic [PreW-1:0] MixedFixNs = 20'd20000;
  localparam logic [PreW-1:0] GreenFixNs = 20'd12000;
  localparam logic [PreW-1:0] Ltf1Ns     = 20'd4000;
  localparam logic [PreW-1:0] Ltf2Ns     = 20'd8000;
  localparam logic [PreW-1:0] Ltf4Ns     = 20'd16000;

  typedef enum logic [CfgIdxW-1:0] {
    CfgSymBase = 2'd0,
    CfgService = 2'd1,
    CfgTail    = 2'd2,
    CfgNone    = 2'd3
  } cfg_idx_e;

  typedef enum logic [ModeW-1:0] {
    PreBasic   = 2'd0,
    PreMixed   = 2'd1,
    PreGreen   = 2'd2,
    PreUnknown = 2'd3
  } pre_mode_e;

  typedef enum logic [1:0] {
    FaultOk   = 2'd0,
    FaultMode = 2'd1,
    FaultBps  = 2'd2,
    FaultRsvd = 2'd3
  } fault_e;

  typedef struct packed {
    logic [RemW-1:0] rem;
    logic [DivW-1:0] num;
    logic [DivW-1:0] quo;
    logic [BpsW-1:0] bps;
    logic [SymW-1:0] sym_ns;
    logic [PreW-1:0] pre_ns;
    fault_e          fault;
  } opa_div_t;

endpackage

[hw/rtl/opa_div_stage.sv]
// One register stage of the restoring divider, retiring several quotient bits.
// Depends on opa_pkg for the stage payload type and the widths.
module opa_div_stage import opa_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     valid_i,
  input  opa_div_t data_i,
  output logic     valid_o,
  output opa_div_t data_o
);

  logic     valid_q;
  opa_div_t data_d, data_q;

  always_comb begin
    logic [RemW:0] trial;
    logic [RemW:0] diff;
    data_d = data_i;
    for (int k = 0; k < StepsPerStage; k++) begin
      trial = {data_d.rem, data_d.num[DivW-1]};
      diff  = trial - {1'b0, data_d.bps};
      data_d.num = {data_d.num[DivW-2:0], 1'b0};
      if (trial >= {1'b0, data_d.bps}) begin
        data_d.rem = diff[RemW-1:0];
        data_d.quo = {data_d.quo[DivW-2:0], 1'b1};
      end else begin
        data_d.rem = trial[RemW-1:0];
        data_d.quo = {data_d.quo[DivW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

[hw/rtl/ofdm_ppdu_airtime.sv]
// Top level of the OFDM PPDU air time calculator: setup, divider pipeline and output.
// Depends on opa_pkg and opa_div_stage.
//
// A frame descriptor is taken in every cycle and never refused, so busy_o is
// always low. Each descriptor gives one result on done_o after passing one
// setup stage, seven divider stages that each retire three bits of the symbol
// count, one multiply stage and the output register. The divider chain sets
// the latency; results leave in the order they came.
module ofdm_ppdu_airtime import opa_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  output logic                busy_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic [PsduW-1:0]    psdu_bits_i,
  input  logic [BpsW-1:0]     bits_per_symbol_i,
  input  logic [StreamW-1:0]  stream_count_i,
  input  logic [ModeW-1:0]    preamble_mode_i,
  input  logic [GuardW-1:0]   guard_ns_i,
  output logic                done_o,
  output logic [AirW-1:0]     airtime_ns_o,
  output logic [SymTotW-1:0]  symbol_total_o,
  output logic [PreW-1:0]     preamble_ns_o,
  output logic [1:0]          fault_o
);

  logic [SymBaseW-1:0] sym_base_q;
  logic [BitsCfgW-1:0] service_q, tail_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sym_base_q <= SymBaseRst;
      service_q  <= ServiceRst;
      tail_q     <= TailRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CfgSymBase: sym_base_q <= cfg_data_i;
        CfgService: service_q  <= cfg_data_i[BitsCfgW-1:0];
        CfgTail:    tail_q     <= cfg_data_i[BitsCfgW-1:0];
        default: ;
      endcase
    end
  end

  assign busy_o = 1'b0;

  logic [SymW-1:0] sym_ns;
  logic [PreW-1:0] sym_pre, ltf_ns, pre_ns;
  logic [DivW-1:0] dividend;
  fault_e          fault;
  opa_div_t        setup;

  assign sym_ns  = SymW'(sym_base_q) + SymW'(guard_ns_i);
  assign sym_pre = PreW'(sym_ns);

  always_comb begin
    case (stream_count_i) inside
      3'd0, 3'd1: ltf_ns = Ltf1Ns;
      3'd2:       ltf_ns = Ltf2Ns;
      default:    ltf_ns = Ltf4Ns;
    endcase
  end

  always_comb begin
    fault = FaultOk;
    unique case (pre_mode_e'(preamble_mode_i))
      PreBasic: pre_ns = BasicFixNs + sym_pre;
      PreMixed: pre_ns = MixedFixNs + ltf_ns + sym_pre + sym_pre + sym_pre;
      PreGreen: pre_ns = GreenFixNs + ltf_ns + sym_pre + sym_pre;
      default: begin
        pre_ns = '0;
        fault  = FaultMode;
      end
    endcase
    if (fault == FaultOk && bits_per_symbol_i == '0) begin
      fault = FaultBps;
    end
  end

  assign dividend = DivW'(psdu_bits_i) + DivW'(service_q) + DivW'(tail_q)
                  + DivW'(bits_per_symbol_i) - DivW'(1);

  always_comb begin
    setup.rem    = '0;
    setup.num    = dividend;
    setup.quo    = '0;
    setup.bps    = bits_per_symbol_i;
    setup.sym_ns = sym_ns;
    setup.pre_ns = pre_ns;
    setup.fault  = fault;
  end

  logic     setup_vld_q;
  opa_div_t setup_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      setup_vld_q <= 1'b0;
    end else begin
      setup_vld_q <= start_i;
    end
  end

  always_ff @(posedge clk_i) begin
    setup_q <= setup;
  end

  logic     [DivStages:0] div_vld;
  opa_div_t               div_data [DivStages+1];

  assign div_vld[0]  = setup_vld_q;
  assign div_data[0] = setup_q;

  for (genvar g = 0; g < DivStages; g++) begin : g_div
    opa_div_stage u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (div_vld[g]),
      .data_i  (div_data[g]),
      .valid_o (div_vld[g+1]),
      .data_o  (div_data[g+1])
    );
  end

  opa_div_t         div_out;
  logic [SymTotW-1:0] nsym_d;
  logic             mul_vld_q;
  logic [ProdW-1:0] prod_q;
  logic [SymTotW-1:0] nsym_q;
  logic [PreW-1:0]  mul_pre_q;
  fault_e           mul_fault_q;

  assign div_out = div_data[DivStages];
  assign nsym_d  = (div_out.quo[DivW-1:SymTotW] != '0) ? '1 : div_out.quo[SymTotW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_vld_q <= 1'b0;
    end else begin
      mul_vld_q <= div_vld[DivStages];
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q      <= ProdW'(nsym_d) * ProdW'(div_out.sym_ns);
    nsym_q      <= nsym_d;
    mul_pre_q   <= div_out.pre_ns;
    mul_fault_q <= div_out.fault;
  end

  logic               done_q;
  logic [AirW-1:0]    air_d, air_q;
  logic [SymTotW-1:0] sym_tot_d, sym_tot_q;
  logic [PreW-1:0]    pre_d, pre_q;
  fault_e             fault_q;

  always_comb begin
    air_d     = AirW'(mul_pre_q) + AirW'(prod_q);
    sym_tot_d = nsym_q;
    pre_d     = mul_pre_q;
    if (mul_fault_q != FaultOk) begin
      air_d     = '0;
      sym_tot_d = '0;
    end
    if (mul_fault_q == FaultMode) begin
      pre_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= mul_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    air_q     <= air_d;
    sym_tot_q <= sym_tot_d;
    pre_q     <= pre_d;
    fault_q   <= mul_fault_q;
  end

  assign done_o         = done_q;
  assign airtime_ns_o   = air_q;
  assign symbol_total_o = sym_tot_q;
  assign preamble_ns_o  = pre_q;
  assign fault_o        = fault_q;

endmodule
